// ----- hdl/ddtf_pkg.sv -----
// decimal degrees text parser: shared types, constants and tables
// no dependencies; used by every module of the block

package ddtf_pkg;

  localparam logic [7:0]  CharNul   = 8'h00;
  localparam logic [7:0]  CharPlus  = 8'h2b;
  localparam logic [7:0]  CharMinus = 8'h2d;
  localparam logic [7:0]  CharPoint = 8'h2e;
  localparam logic [7:0]  CharZero  = 8'h30;

  localparam logic [1:0]  MaxIntDigits   = 2'd3;
  localparam logic [2:0]  MaxFracDigits  = 3'd7;
  localparam logic [7:0]  LimitCeiling   = 8'd214;
  localparam logic [31:0] UnitsPerDegree = 32'd10000000;

  // finished text, handed from the parser to the result stage
  typedef struct packed {
    logic        ok;
    logic        negative;
    logic [7:0]  int_deg;
    logic [23:0] frac_units;
  } ddtf_fin_t;

  // weight of the next fraction digit in 1e-7 degree
  function automatic logic [23:0] frac_weight(input logic [2:0] count);
    logic [23:0] w;
    case (count)
      3'd0:    w = 24'd1000000;
      3'd1:    w = 24'd100000;
      3'd2:    w = 24'd10000;
      3'd3:    w = 24'd1000;
      3'd4:    w = 24'd100;
      3'd5:    w = 24'd10;
      3'd6:    w = 24'd1;
      default: w = 24'd0;
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/ddtf_parser.sv -----
// character scanner: text state, digit accumulation and the finished-text register
// depends on ddtf_pkg

module ddtf_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          char_code_i,
  input  logic [7:0]          limit_degrees_i,
  input  logic                fin_adv_i,
  output logic                fin_valid_o,
  output ddtf_pkg::ddtf_fin_t fin_o
);
  import ddtf_pkg::*;

  logic        at_start_q, at_start_d;
  logic        negative_q, negative_d;
  logic        point_q, point_d;
  logic        bad_q, bad_d;
  logic [1:0]  int_cnt_q, int_cnt_d;
  logic [2:0]  frac_cnt_q, frac_cnt_d;
  logic [9:0]  int_q, int_d;
  logic [23:0] frac_q, frac_d;
  logic        fin_valid_q, fin_valid_d;
  ddtf_fin_t   fin_q, fin_d;

  logic        is_nul;
  logic [7:0]  digit_off;
  logic        is_digit;
  logic [3:0]  digit;
  logic [7:0]  limit;
  logic        in_limit;
  logic        well_formed;

  assign is_nul    = (char_code_i == CharNul);
  assign digit_off = char_code_i - CharZero;
  assign is_digit  = (digit_off < 8'd10);
  assign digit     = digit_off[3:0];
  assign limit     = (limit_degrees_i > LimitCeiling) ? LimitCeiling : limit_degrees_i;
  assign in_limit  = (int_q < {2'd0, limit}) ||
                     ((int_q == {2'd0, limit}) && (frac_q == 24'd0));
  assign well_formed = !bad_q && (int_cnt_q != 2'd0) && !(point_q && (frac_cnt_q == 3'd0));

  always_comb begin
    at_start_d = at_start_q;
    negative_d = negative_q;
    point_d    = point_q;
    bad_d      = bad_q;
    int_cnt_d  = int_cnt_q;
    frac_cnt_d = frac_cnt_q;
    int_d      = int_q;
    frac_d     = frac_q;
    fin_d.ok         = well_formed && in_limit;
    fin_d.negative   = negative_q;
    fin_d.int_deg    = int_q[7:0];
    fin_d.frac_units = frac_q;
    if (accept_i) begin
      if (is_nul) begin
        at_start_d = 1'b1;
        negative_d = 1'b0;
        point_d    = 1'b0;
        bad_d      = 1'b0;
        int_cnt_d  = 2'd0;
        frac_cnt_d = 3'd0;
        int_d      = 10'd0;
        frac_d     = 24'd0;
      end else begin
        at_start_d = 1'b0;
        if (!bad_q) begin
          if ((char_code_i == CharPlus) || (char_code_i == CharMinus)) begin
            if (at_start_q) begin
              negative_d = (char_code_i == CharMinus);
            end else begin
              bad_d = 1'b1;
            end
          end else if (char_code_i == CharPoint) begin
            if (point_q) begin
              bad_d = 1'b1;
            end else begin
              point_d = 1'b1;
            end
          end else if (is_digit) begin
            if (!point_q) begin
              if (int_cnt_q == MaxIntDigits) begin
                bad_d = 1'b1;
              end else begin
                int_cnt_d = int_cnt_q + 2'd1;
                int_d     = int_q * 10'd10 + {6'd0, digit};
              end
            end else begin
              if (frac_cnt_q == MaxFracDigits) begin
                bad_d = 1'b1;
              end else begin
                frac_cnt_d = frac_cnt_q + 3'd1;
                frac_d     = frac_q + {20'd0, digit} * frac_weight(frac_cnt_q);
              end
            end
          end else begin
            bad_d = 1'b1;
          end
        end
      end
    end
  end

  assign fin_valid_d = (accept_i && is_nul) ? 1'b1 : (fin_adv_i ? 1'b0 : fin_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q  <= 1'b1;
      negative_q  <= 1'b0;
      point_q     <= 1'b0;
      bad_q       <= 1'b0;
      int_cnt_q   <= 2'd0;
      frac_cnt_q  <= 3'd0;
      int_q       <= 10'd0;
      frac_q      <= 24'd0;
      fin_valid_q <= 1'b0;
    end else begin
      at_start_q  <= at_start_d;
      negative_q  <= negative_d;
      point_q     <= point_d;
      bad_q       <= bad_d;
      int_cnt_q   <= int_cnt_d;
      frac_cnt_q  <= frac_cnt_d;
      int_q       <= int_d;
      frac_q      <= frac_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && is_nul) begin
      fin_q <= fin_d;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

endmodule

// ----- hdl/ddtf_result.sv -----
// result stage: scales the finished text to 1e-7 degree and holds the output register
// depends on ddtf_pkg

module ddtf_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fin_valid_i,
  input  ddtf_pkg::ddtf_fin_t fin_i,
  output logic                fin_adv_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                valid_res_o,
  output logic signed [31:0]  value_1e7_o
);
  import ddtf_pkg::*;

  logic               out_valid_q, out_valid_d;
  logic               valid_res_q;
  logic signed [31:0] value_q, value_d;
  logic [31:0]        mag;
  logic               out_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign fin_adv_o = fin_valid_i && out_ready;

  assign mag = {24'd0, fin_i.int_deg} * UnitsPerDegree + {8'd0, fin_i.frac_units};

  always_comb begin
    value_d = 32'sd0;
    if (fin_i.ok) begin
      value_d = fin_i.negative ? -$signed(mag) : $signed(mag);
    end
  end

  assign out_valid_d = fin_adv_o ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_adv_o) begin
      valid_res_q <= fin_i.ok;
      value_q     <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;
  assign value_1e7_o = value_q;

endmodule

// ----- hdl/decimal_degrees_text_to_fixed.sv -----
// decimal degrees text to fixed point, top level
// depends on ddtf_pkg, ddtf_parser and ddtf_result
//
// usage:
//   input channel (in_valid_i / in_stall_o) carries one ASCII character per
//   transfer in char_code_i; a NUL character ends the text and its transfer
//   also carries limit_degrees_i (values above 214 act as 214)
//   output channel (out_valid_o / out_stall_i) gives one
//   result per ended text: valid_res_o and value_1e7_o in 1e-7 degree,
//   value zero whenever valid_res_o is low
//   throughput: one character per cycle while in_stall_o is low; characters of
//   the next text may follow the NUL directly
//   path: after the NUL transfer the result passes the finished-text register
//   and then the output register before it can transfer
//   reset: parser returns to the start of a text, no result pending
//   stall: a result waits in the output register; while it waits a second
//   finished text is held in the finished-text register, and only when both
//   are occupied does in_stall_o rise

module decimal_degrees_text_to_fixed (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic [7:0]         limit_degrees_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               valid_res_o,
  output logic signed [31:0] value_1e7_o
);
  import ddtf_pkg::*;

  logic      accept;
  logic      fin_valid;
  logic      fin_adv;
  ddtf_fin_t fin;

  assign in_stall_o = fin_valid && out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  ddtf_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .char_code_i     (char_code_i),
    .limit_degrees_i (limit_degrees_i),
    .fin_adv_i       (fin_adv),
    .fin_valid_o     (fin_valid),
    .fin_o           (fin)
  );

  ddtf_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_valid_i (fin_valid),
    .fin_i       (fin),
    .fin_adv_o   (fin_adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .valid_res_o (valid_res_o),
    .value_1e7_o (value_1e7_o)
  );

`ifndef ASSERT_OFF
  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (value_1e7_o == 32'sd0))
    else $error("invalid result with nonzero value");

  a_value_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |->
      ((value_1e7_o <= 32'sd2140000000) && (value_1e7_o >= -32'sd2140000000)))
    else $error("valid result beyond degree ceiling");

  a_nul_fills_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (char_code_i == CharNul)) |=> fin_valid)
    else $error("ended text not held for the result stage");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (fin_valid && out_valid_o))
    else $error("input stalled with room downstream");
`endif

endmodule
